### hdl/swstat_pkg.sv
// swstat_pkg: shared constants, types and state codes of the sliding window statistics block.
// No dependencies; used by the channel interfaces and every module of the block.
package swstat_pkg;

   localparam int SAMPLE_W           = 32;
   localparam int OUT_W              = 32;
   localparam int LEN_W              = 7;
   localparam logic [LEN_W-1:0] LEN_RESET = 7'd20;
   localparam int WINDOW_MAX_DEFAULT  = 64;
   localparam int SAMPLE_BITS_DEFAULT = 32;

   typedef struct packed {
      logic push;
      logic restart;
   } swstat_push_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIVIDE_MEAN,
      ST_SPREAD,
      ST_SCALE,
      ST_VAR_START,
      ST_DIVIDE_VAR,
      ST_ROOT,
      ST_DELIVER
   } swstat_state_type;

endpackage

### hdl/swstat_if.sv
// swstat_if: valid/ready channels of the block (sample input, result output, length write).
// Depends on swstat_pkg for the field widths.
interface swstat_req_if;
   logic                            valid;
   logic                            ready;
   logic [swstat_pkg::SAMPLE_W-1:0] sample;
   logic                            restart;
   modport source (output valid, sample, restart, input ready);
   modport sink   (input valid, sample, restart, output ready);
endinterface

interface swstat_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [swstat_pkg::OUT_W-1:0] window_mean;
   logic [swstat_pkg::OUT_W-1:0] window_deviation;
   logic                         deviation_undefined;
   logic [swstat_pkg::OUT_W-1:0] window_maximum;
   logic [swstat_pkg::OUT_W-1:0] window_minimum;
   modport source (output valid, window_mean, window_deviation, deviation_undefined,
                   window_maximum, window_minimum, input ready);
   modport sink   (input valid, window_mean, window_deviation, deviation_undefined,
                   window_maximum, window_minimum, output ready);
endinterface

interface swstat_csr_if;
   logic                         valid;
   logic                         ready;
   logic [swstat_pkg::LEN_W-1:0] window_length;
   modport source (output valid, window_length, input ready);
   modport sink   (input valid, window_length, output ready);
endinterface

### hdl/sliding_window_statistics.sv
// sliding_window_statistics: mean, sample deviation, maximum and minimum over a sample window.
// An item that fills no window is only written to the ring; one with a result passes the ring
// scan and mean division, and for n > 1 also the spread scan, variance division and root unit.
// One item at a time; the next item is taken once the result sits in the output register.
// Reset clears control, fill count and write slot and sets the window length to 20.
module sliding_window_statistics #(
   parameter int WINDOW_MAX  = swstat_pkg::WINDOW_MAX_DEFAULT,
   parameter int SAMPLE_BITS = swstat_pkg::SAMPLE_BITS_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   swstat_req_if.sink   req_if,
   swstat_rsp_if.source rsp_if,
   swstat_csr_if.sink   csr_if
);
   import swstat_pkg::*;

   localparam int SW   = SAMPLE_BITS;
   localparam int AW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int NW   = $clog2(WINDOW_MAX + 1);
   localparam int SUMW = SW + NW;
   localparam int SQW  = 2 * SW + NW;
   localparam int QW   = SQW + NW;
   localparam int DVW  = 2 * NW;
   localparam int RW   = (QW + 1) / 2;
   localparam int RWE  = RW + OUT_W;
   localparam int H    = (SW + 1) / 2;
   localparam int HL   = SW - H;
   localparam int EXW  = SW + OUT_W;

   swstat_state_type state_ff, state_in;

   logic [LEN_W-1:0] len_ff;
   logic [NW-1:0]    n_eff, n_ff;
   logic [NW-1:0]    issue_ff;
   logic [AW-1:0]    addr_ff, addr_dec, base_ff;
   logic             rd_v_ff, d_v_ff, p_v_ff;
   logic             rsp_valid_ff, rsp_valid_in;

   logic accept, req_ready, rd_en, div_start, root_start, rsp_load;
   logic scan_done, spread_done;

   swstat_push_type    push;
   logic [SW-1:0]      x;
   logic [AW-1:0]      slot;
   logic [NW-1:0]      fill_next;
   logic [SW-1:0]      rd_data;
   logic signed [SW-1:0] rd_s;

   logic signed [SUMW-1:0] sum_ff;
   logic [SUMW-1:0]        sum_mag;
   logic signed [SW-1:0]   max_ff, min_ff, mean_ff;
   logic [NW-1:0]          r_ff;
   logic                   undef_ff;
   logic signed [SW:0]     diff;
   logic [SW-1:0]          d_ff;
   logic [2*H-1:0]         pll_ff;
   logic [H+HL-1:0]        plh_ff;
   logic [2*HL-1:0]        phh_ff;
   logic [SQW-1:0]         sq_ff;
   logic [QW-1:0]          num_ff;
   logic [DVW-1:0]         dd_ff;
   logic [OUT_W-1:0]       dev_ff;

   logic [QW-1:0]  div_a, div_q;
   logic [DVW-1:0] div_b, div_r;
   logic           div_done;
   logic [RW-1:0]  root;
   logic           root_done;
   logic [RWE-1:0] root_ext;
   logic [SW-1:0]  mean_mag;

   logic [OUT_W-1:0] mean_o_ff, dev_o_ff, max_o_ff, min_o_ff;
   logic             undef_o_ff;
   logic signed [EXW-1:0] mean_x, max_x, min_x;

   // sample: low SAMPLE_BITS of the field, zero extended first when wider
   assign x = SW'({{SW{1'b0}}, req_if.sample});

   always_comb begin
      if (32'(len_ff) > WINDOW_MAX) begin
         n_eff = NW'(WINDOW_MAX);
      end else if (len_ff == '0) begin
         n_eff = NW'(1);
      end else begin
         n_eff = NW'(len_ff);
      end
   end

   assign accept       = req_if.valid && req_ready;
   assign push.push    = accept;
   assign push.restart = req_if.restart;
   assign addr_dec     = (addr_ff == '0) ? AW'(WINDOW_MAX - 1) : addr_ff - AW'(1);
   assign scan_done    = (issue_ff == '0) && !rd_v_ff;
   assign spread_done  = (issue_ff == '0) && !rd_v_ff && !d_v_ff && !p_v_ff;
   assign rd_s         = $signed(rd_data);
   assign sum_mag      = sum_ff[SUMW-1] ? SUMW'(-sum_ff) : SUMW'(sum_ff);
   assign diff         = (SW+1)'(rd_s) - (SW+1)'(mean_ff);
   assign mean_mag     = div_q[SW-1:0];
   assign root_ext     = RWE'(root);

   swstat_ring #(.WINDOW_MAX(WINDOW_MAX), .SAMPLE_BITS(SAMPLE_BITS)) u_ring (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (x),
      .slot      (slot),
      .fill_next (fill_next),
      .rd_en     (rd_en),
      .rd_addr   (addr_ff),
      .rd_data   (rd_data)
   );

   always_comb begin
      if (state_ff == ST_SCAN) begin
         div_a = QW'(sum_mag);
         div_b = DVW'(n_ff);
      end else begin
         div_a = num_ff;
         div_b = dd_ff;
      end
   end

   swstat_div #(.QW(QW), .DW(DVW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   swstat_sqrt #(.IW(QW)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (div_q),
      .done     (root_done),
      .root     (root)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (fill_next >= n_eff)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_DIVIDE_MEAN;
            end
         end
         ST_DIVIDE_MEAN: begin
            if (div_done) begin
               state_in = (n_ff == NW'(1)) ? ST_DELIVER : ST_SPREAD;
            end
         end
         ST_SPREAD: begin
            if (spread_done) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE:     state_in = ST_VAR_START;
         ST_VAR_START: state_in = ST_DIVIDE_VAR;
         ST_DIVIDE_VAR: begin
            if (div_done) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (root_done) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready  = 1'b0;
      rd_en      = 1'b0;
      div_start  = 1'b0;
      root_start = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE:       req_ready  = 1'b1;
         ST_SCAN: begin
            rd_en     = issue_ff != '0;
            div_start = scan_done;
         end
         ST_SPREAD:     rd_en      = issue_ff != '0;
         ST_VAR_START:  div_start  = 1'b1;
         ST_DIVIDE_VAR: root_start = div_done;
         ST_DELIVER:    rsp_load   = !rsp_valid_ff || rsp_if.ready;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= LEN_RESET;
         issue_ff     <= '0;
         rd_v_ff      <= 1'b0;
         d_v_ff       <= 1'b0;
         p_v_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_v_ff      <= rd_en;
         d_v_ff       <= rd_v_ff && (state_ff == ST_SPREAD);
         p_v_ff       <= d_v_ff;
         if (csr_if.valid) begin
            len_ff <= csr_if.window_length;
         end
         if (accept) begin
            issue_ff <= n_eff;
         end else if (state_ff == ST_DIVIDE_MEAN && div_done) begin
            issue_ff <= n_ff;
         end else if (rd_en) begin
            issue_ff <= issue_ff - NW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         n_ff    <= n_eff;
         base_ff <= slot;
         addr_ff <= slot;
         sum_ff  <= '0;
         max_ff  <= $signed(x);
         min_ff  <= $signed(x);
      end else if (state_ff == ST_DIVIDE_MEAN && div_done) begin
         addr_ff <= base_ff;
      end else if (rd_en) begin
         addr_ff <= addr_dec;
      end

      if (rd_v_ff && state_ff == ST_SCAN) begin
         sum_ff <= sum_ff + SUMW'(rd_s);
         if (rd_s > max_ff) begin
            max_ff <= rd_s;
         end
         if (rd_s < min_ff) begin
            min_ff <= rd_s;
         end
      end

      if (state_ff == ST_DIVIDE_MEAN && div_done) begin
         mean_ff  <= sum_ff[SUMW-1] ? $signed(-mean_mag) : $signed(mean_mag);
         r_ff     <= div_r[NW-1:0];
         undef_ff <= n_ff == NW'(1);
         sq_ff    <= '0;
         dev_ff   <= '0;
      end

      d_ff   <= diff[SW] ? SW'(-diff) : SW'(diff);
      pll_ff <= (2*H)'(d_ff[H-1:0]) * (2*H)'(d_ff[H-1:0]);
      plh_ff <= (H+HL)'(d_ff[H-1:0]) * (H+HL)'(d_ff[SW-1:H]);
      phh_ff <= (2*HL)'(d_ff[SW-1:H]) * (2*HL)'(d_ff[SW-1:H]);
      if (p_v_ff) begin
         sq_ff <= sq_ff + SQW'(pll_ff) + (SQW'(plh_ff) << (H + 1))
                  + (SQW'(phh_ff) << (2 * H));
      end

      if (state_ff == ST_SCALE) begin
         num_ff <= QW'(sq_ff) * QW'(n_ff) - QW'(DVW'(r_ff) * DVW'(r_ff));
         dd_ff  <= DVW'(n_ff) * DVW'(n_ff - NW'(1));
      end

      if (root_done) begin
         dev_ff <= (root_ext > RWE'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : OUT_W'(root_ext);
      end
   end

   assign mean_x = EXW'(mean_ff);
   assign max_x  = EXW'(max_ff);
   assign min_x  = EXW'(min_ff);

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         mean_o_ff  <= mean_x[OUT_W-1:0];
         dev_o_ff   <= dev_ff;
         undef_o_ff <= undef_ff;
         max_o_ff   <= max_x[OUT_W-1:0];
         min_o_ff   <= min_x[OUT_W-1:0];
      end
   end

   assign req_if.ready               = req_ready;
   assign csr_if.ready               = 1'b1;
   assign rsp_if.valid               = rsp_valid_ff;
   assign rsp_if.window_mean         = mean_o_ff;
   assign rsp_if.window_deviation    = dev_o_ff;
   assign rsp_if.deviation_undefined = undef_o_ff;
   assign rsp_if.window_maximum      = max_o_ff;
   assign rsp_if.window_minimum      = min_o_ff;

   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVIDE_MEAN || state_ff == ST_DIVIDE_VAR))
      else $error("divider result outside a divide step");
   a_root_next: assert property (@(posedge clock) disable iff (reset)
      root_done |=> state_ff == ST_DELIVER)
      else $error("root result not delivered");
   a_spread_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SPREAD && state_in == ST_SCALE) |-> (!d_v_ff && !p_v_ff))
      else $error("squares still in flight at scaling");
   a_read_state: assert property (@(posedge clock) disable iff (reset)
      rd_v_ff |-> (state_ff == ST_SCAN || state_ff == ST_SPREAD))
      else $error("ring data returned outside a scan");

endmodule

### hdl/swstat_ring.sv
// swstat_ring: sample ring memory with write slot and fill count.
// Depends on swstat_pkg.
module swstat_ring #(
   parameter int WINDOW_MAX  = swstat_pkg::WINDOW_MAX_DEFAULT,
   parameter int SAMPLE_BITS = swstat_pkg::SAMPLE_BITS_DEFAULT,
   localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
   localparam int NW = $clog2(WINDOW_MAX + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  swstat_pkg::swstat_push_type push,
   input  logic [SAMPLE_BITS-1:0]      push_data,
   output logic [AW-1:0]               slot,
   output logic [NW-1:0]               fill_next,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   output logic [SAMPLE_BITS-1:0]      rd_data
);
   import swstat_pkg::*;

   logic [SAMPLE_BITS-1:0] mem [WINDOW_MAX];
   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic [AW-1:0]          slot_ff, slot_in;
   logic [NW-1:0]          fill_ff;
   logic [NW-1:0]          fill_base;

   always_comb begin
      fill_base = push.restart ? '0 : fill_ff;
      fill_next = (fill_base < NW'(WINDOW_MAX)) ? fill_base + NW'(1) : fill_base;
      slot_in   = (slot_ff == AW'(WINDOW_MAX - 1)) ? '0 : slot_ff + AW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         fill_ff <= '0;
      end else if (push.push) begin
         slot_ff <= slot_in;
         fill_ff <= fill_next;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push) begin
         mem[slot_ff] <= push_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign slot    = slot_ff;
   assign rd_data = rd_data_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= NW'(WINDOW_MAX))
      else $error("fill count beyond window depth");
   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= AW'(WINDOW_MAX - 1))
      else $error("write slot beyond window depth");
   a_no_collide: assert property (@(posedge clock) disable iff (reset)
      push.push |-> !rd_en)
      else $error("read issued together with a sample write");

endmodule

### hdl/swstat_div.sv
// swstat_div: serial restoring divider, one quotient bit per cycle.
// Depends on swstat_pkg.
module swstat_div #(
   parameter int QW = 78,
   parameter int DW = 14,
   localparam int CW = $clog2(QW + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [QW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [QW-1:0] quotient,
   output logic [DW-1:0] remainder
);
   import swstat_pkg::*;

   logic [QW-1:0] quo_ff;
   logic [DW-1:0] rem_ff;
   logic [DW-1:0] dvs_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [DW:0]   trial;
   logic          fits;

   always_comb begin
      trial = {rem_ff, quo_ff[QW-1]};
      fits  = trial >= {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(QW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[QW-2:0], fits};
         rem_ff <= fits ? DW'(trial - {1'b0, dvs_ff}) : DW'(trial);
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   a_done_once: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held");
   a_idle_start: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");
   a_done_after: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without work");

endmodule

### hdl/swstat_sqrt.sv
// swstat_sqrt: serial floor square root, one root bit per cycle.
// Depends on swstat_pkg.
module swstat_sqrt #(
   parameter int IW = 78,
   localparam int RW = (IW + 1) / 2,
   localparam int CW = $clog2(RW + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [IW-1:0] radicand,
   output logic          done,
   output logic [RW-1:0] root
);
   import swstat_pkg::*;

   logic [2*RW-1:0] rad_ff;
   logic [RW:0]     rem_ff;
   logic [RW-1:0]   root_ff;
   logic [CW-1:0]   cnt_ff;
   logic            busy_ff;
   logic            done_ff;
   logic [RW+2:0]   rem_sh;
   logic [RW+2:0]   trial;
   logic            fits;

   always_comb begin
      rem_sh = {rem_ff, rad_ff[2*RW-1:2*RW-2]};
      trial  = (RW+3)'({root_ff, 2'b01});
      fits   = rem_sh >= trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(RW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= (2*RW)'(radicand);
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[2*RW-3:0], 2'b00};
         rem_ff  <= fits ? (RW+1)'(rem_sh - trial) : (RW+1)'(rem_sh);
         root_ff <= {root_ff[RW-2:0], fits};
      end
   end

   assign done = done_ff;
   assign root = root_ff;

   a_done_once: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("root done held");
   a_idle_start: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("root restarted while busy");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> ((RW+2)'(rem_ff) <= (RW+2)'({root_ff, 1'b0})))
      else $error("root remainder out of range");

endmodule
